// ===== rtl/sis_pkg.sv =====
// Shared types, constants and helper functions of the seam image store.
// Used by every module of the block; depends on nothing else.
package sis_pkg;

  // Fixed widths of the item and result fields.
  localparam int SIZE_BITS  = 10;
  localparam int COORD_BITS = 9;
  localparam int VALUE_BITS = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_PIXEL_BITS = 8;

  // Size registers after reset.
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 10'd512;

  // Number of taps in the read window.
  localparam int WIN_TAPS = 9;

  typedef logic [SIZE_BITS-1:0]  size_t;
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [VALUE_BITS-1:0] byte_t;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_READ    = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam logic REG_INIT_WIDTH  = 1'b0;
  localparam logic REG_INIT_HEIGHT = 1'b1;

  typedef struct packed {
    cmd_t   command;
    coord_t row;
    coord_t col;
    byte_t  value;
    logic   orientation;
    logic   seam_last;
  } item_t;

  typedef struct packed {
    byte_t win_tl;
    byte_t win_t;
    byte_t win_tr;
    byte_t win_l;
    byte_t win_c;
    byte_t win_r;
    byte_t win_bl;
    byte_t win_b;
    byte_t win_br;
    size_t cur_width;
    size_t cur_height;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the item into the request register
    logic pix_wr;    // store the item's pixel
    logic win_rd;    // read the window tap selected by the step counter
    logic gone_rd;   // read the pixel that the seam point removes
    logic shift_rd;  // read the next pixel along the shift axis
    logic gone_wr;   // store the removed pixel at the end of the line
    logic finish;    // update the size and present the result
  } sis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t command;
    logic in_image;
    logic win_end;
    logic shift_end;
  } sis_stat_t;

  // Window offsets are coded 0 for -1, 1 for 0 and 2 for +1.
  function automatic logic [1:0] win_row_step(input logic [3:0] tap);
    logic [1:0] step;
    case (tap)
      4'd0, 4'd1, 4'd2: step = 2'd0;
      4'd3, 4'd4, 4'd5: step = 2'd1;
      default:          step = 2'd2;
    endcase
    return step;
  endfunction

  function automatic logic [1:0] win_col_step(input logic [3:0] tap);
    logic [1:0] step;
    case (tap)
      4'd0, 4'd3, 4'd6: step = 2'd0;
      4'd1, 4'd4, 4'd7: step = 2'd1;
      default:          step = 2'd2;
    endcase
    return step;
  endfunction

  // Moves a coordinate by a coded offset and clamps it into [0, limit-1].
  function automatic size_t clamp_coord(input size_t coord, input logic [1:0] step,
                                        input size_t limit);
    logic [SIZE_BITS:0] moved;
    logic [SIZE_BITS:0] top;
    size_t              res;
    moved = {1'b0, coord} + (SIZE_BITS + 1)'(step);
    top   = {1'b0, limit} - (SIZE_BITS + 1)'(1);
    if (moved == '0) begin
      res = '0;
    end else if (moved - (SIZE_BITS + 1)'(1) > top) begin
      res = top[SIZE_BITS-1:0];
    end else begin
      res = SIZE_BITS'(moved - (SIZE_BITS + 1)'(1));
    end
    return res;
  endfunction

endpackage

// ===== rtl/sis_ctrl.sv =====
// Controller state machine of the seam image store.
// Depends on sis_pkg for the command and status structs.
module sis_ctrl import sis_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  sis_stat_t stat,
  output logic      busy,
  output sis_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_WIN      = 9'b000000100,
    S_WIN_WAIT = 9'b000001000,
    S_GONE     = 9'b000010000,
    S_SHIFT    = 9'b000100000,
    S_DRAIN    = 9'b001000000,
    S_TAIL     = 9'b010000000,
    S_FINISH   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.command)
          CMD_WRITE: begin
            cmd.pix_wr = stat.in_image;
            state_next = S_FINISH;
          end
          CMD_READ: begin
            state_next = S_WIN;
          end
          CMD_REMOVE: begin
            state_next = stat.in_image ? S_GONE : S_FINISH;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_WIN: begin
        cmd.win_rd = 1'b1;
        if (stat.win_end) begin
          state_next = S_WIN_WAIT;
        end
      end
      S_WIN_WAIT: begin
        state_next = S_FINISH;
      end
      S_GONE: begin
        cmd.gone_rd = 1'b1;
        state_next  = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.shift_end) begin
          state_next = S_DRAIN;
        end else begin
          cmd.shift_rd = 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_TAIL;
      end
      S_TAIL: begin
        cmd.gone_wr = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sis_dp.sv =====
// Datapath of the seam image store: pixel memory, size and config registers,
// window registers and the result register. Depends on sis_pkg.
module sis_dp import sis_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  item_t     item,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  size_t     cfg_data,
  input  sis_cmd_t  cmd,
  output sis_stat_t stat,
  output logic      done,
  output result_t   result
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_GONE,
    TAG_SHIFT,
    TAG_WIN
  } tag_t;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  function automatic logic [AW-1:0] pix_addr(input size_t r, input size_t c);
    return AW'(r) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  function automatic size_t clamp_size(input size_t v, input int maxv);
    size_t res;
    if (v == '0) begin
      res = SIZE_BITS'(1);
    end else if (32'(v) > maxv) begin
      res = SIZE_BITS'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  pix_t  mem [DEPTH];
  pix_t  rdata;
  pix_t  gone;
  item_t req;
  size_t init_width;
  size_t init_height;
  size_t width_now;
  size_t height_now;
  size_t width_next;
  size_t height_next;
  size_t idx;
  size_t tag_pos;
  tag_t  tag;
  byte_t win [WIN_TAPS];

  logic          horiz;
  size_t         row_w;
  size_t         col_w;
  size_t         pos;
  size_t         lim;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;
  pix_t          wdata;
  logic [15:0]   val_wide;
  logic [15:0]   rd_wide;

  assign horiz    = req.orientation;
  assign row_w    = SIZE_BITS'(req.row);
  assign col_w    = SIZE_BITS'(req.col);
  assign pos      = horiz ? row_w : col_w;
  assign lim      = horiz ? height_now : width_now;
  assign val_wide = 16'(req.value);
  assign rd_wide  = 16'(rdata);

  assign stat.command   = req.command;
  assign stat.in_image  = (row_w < height_now) && (col_w < width_now);
  assign stat.win_end   = (idx == SIZE_BITS'(WIN_TAPS - 1));
  assign stat.shift_end = (idx >= lim);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_width  <= SIZE_RESET;
      init_height <= SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_INIT_WIDTH) begin
        init_width <= cfg_data;
      end else begin
        init_height <= cfg_data;
      end
    end
  end

  // Read address.
  always_comb begin
    raddr = pix_addr(row_w, col_w);
    if (cmd.win_rd) begin
      raddr = pix_addr(clamp_coord(row_w, win_row_step(idx[3:0]), height_now),
                       clamp_coord(col_w, win_col_step(idx[3:0]), width_now));
    end else if (cmd.shift_rd) begin
      raddr = horiz ? pix_addr(idx, col_w) : pix_addr(row_w, idx);
    end
  end

  // Write port: pixel write, shifted pixel, or the removed pixel at the end.
  always_comb begin
    we    = 1'b0;
    waddr = pix_addr(row_w, col_w);
    wdata = val_wide[PIXEL_BITS-1:0];
    if (cmd.pix_wr) begin
      we = 1'b1;
    end else if (tag == TAG_SHIFT) begin
      we    = 1'b1;
      waddr = horiz ? pix_addr(tag_pos, col_w) : pix_addr(row_w, tag_pos);
      wdata = rdata;
    end else if (cmd.gone_wr) begin
      we    = 1'b1;
      waddr = horiz ? pix_addr(lim - SIZE_BITS'(1), col_w)
                    : pix_addr(row_w, lim - SIZE_BITS'(1));
      wdata = gone;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Size after the current command.
  always_comb begin
    width_next  = width_now;
    height_next = height_now;
    case (req.command)
      CMD_RESTART: begin
        width_next  = clamp_size(init_width, MAX_WIDTH);
        height_next = clamp_size(init_height, MAX_HEIGHT);
      end
      CMD_REMOVE: begin
        if (req.seam_last) begin
          if (horiz) begin
            if (height_now > SIZE_BITS'(1)) height_next = height_now - SIZE_BITS'(1);
          end else begin
            if (width_now > SIZE_BITS'(1)) width_next = width_now - SIZE_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers: sizes, step counter, read tag and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_now  <= clamp_size(SIZE_RESET, MAX_WIDTH);
      height_now <= clamp_size(SIZE_RESET, MAX_HEIGHT);
      idx        <= '0;
      tag        <= TAG_NONE;
      done       <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        width_now  <= width_next;
        height_now <= height_next;
      end
      if (cmd.capture) begin
        idx <= '0;
      end else if (cmd.gone_rd) begin
        idx <= pos + SIZE_BITS'(1);
      end else if (cmd.win_rd || cmd.shift_rd) begin
        idx <= idx + SIZE_BITS'(1);
      end
      if (cmd.win_rd) begin
        tag <= TAG_WIN;
      end else if (cmd.gone_rd) begin
        tag <= TAG_GONE;
      end else if (cmd.shift_rd) begin
        tag <= TAG_SHIFT;
      end else begin
        tag <= TAG_NONE;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= item;
    end
    tag_pos <= cmd.win_rd ? idx : idx - SIZE_BITS'(1);
    if (tag == TAG_GONE) begin
      gone <= rdata;
    end
    for (int k = 0; k < WIN_TAPS; k++) begin
      if (cmd.capture) begin
        win[k] <= '0;
      end else if (tag == TAG_WIN && tag_pos[3:0] == 4'(k)) begin
        win[k] <= rd_wide[VALUE_BITS-1:0];
      end
    end
    if (cmd.finish) begin
      result.win_tl     <= win[0];
      result.win_t      <= win[1];
      result.win_tr     <= win[2];
      result.win_l      <= win[3];
      result.win_c      <= win[4];
      result.win_r      <= win[5];
      result.win_bl     <= win[6];
      result.win_b      <= win[7];
      result.win_br     <= win[8];
      result.cur_width  <= width_next;
      result.cur_height <= height_next;
    end
  end

endmodule

// ===== rtl/seam_image_store_unit.sv =====
// Top level of the seam image store: controller and datapath.
// Depends on sis_pkg, sis_ctrl and sis_dp.
//
//   Channel     Signals                         Transfer
//   ---------   -----------------------------   ---------------------------------
//   command     start, busy, item               start high while busy is low
//   result      done, result                    done high for one cycle, no stall
//   config      cfg_we, cfg_index, cfg_data     cfg_we high at a clock edge
//
// Restart and write items go straight from the dispatch state to the finish state.
// A read item does nine window reads from the single memory read port, one per
// cycle, then waits for the registered read before it finishes.
// A seam point removal reads the removed pixel, shifts the rest of the line
// one pixel per cycle through the memory's one read and one write port, and
// stores the removed pixel at the end. A point outside the image goes to finish.
// Reset is synchronous and active high; it restores the sizes and config
// registers but leaves the pixel memory as it was. The result cannot be
// stalled, and a new item may be accepted in the cycle that shows a result.
module seam_image_store_unit import sis_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result,
  input  logic    cfg_we,
  input  logic    cfg_index,
  input  size_t   cfg_data
);

  // The controller sequences each item; the datapath holds all storage.
  sis_cmd_t  cmd;
  sis_stat_t stat;

  sis_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath owns the pixel memory, so the image size parameters go there.
  sis_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== rtl/sis_checker.sv =====
// Port-level checks of the seam image store, bound to the top level.
// Depends on sis_pkg and seam_image_store_unit.
module sis_checker import sis_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    done,
  input result_t result,
  input logic    cfg_we,
  input logic    cfg_index,
  input size_t   cfg_data
);

  // An accepted item always keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // A write item's result follows acceptance through the dispatch and finish states.
  a_write_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.command == CMD_WRITE) |-> ##3 done)
    else $error("write item result late or missing");

  // Each item's result strobe lasts a single cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // The image never shrinks to nothing.
  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.cur_width != '0 && result.cur_height != '0))
    else $error("result reports an empty image");

endmodule

bind seam_image_store_unit sis_checker u_sis_checker (.*);
